[design/gvw_pkg.sv]
// Shared types and constants for the grid vertex welder.
// No dependencies.
package gvw_pkg;
  localparam int Capacity = 4096;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = IdxW + 1;
  localparam logic KIND_WELD = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_DIVX, ST_DIVY, ST_HASH, ST_RD, ST_CMP, ST_OUT
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] vertex_index;
    logic        is_new;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic        table_full;
    logic [12:0] unique_count;
  } out_beat_t;
endpackage

[design/gvw_if.sv]
// Valid/ready channels: gvw_in_if carries one in_beat_t, gvw_out_if one out_beat_t.
// Depends on gvw_pkg for beat types.
interface gvw_in_if (input logic clk);
  import gvw_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface gvw_out_if (input logic clk);
  import gvw_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/gvw_div.sv]
// Serial floor divider: signed 32-bit dividend by unsigned 31-bit divisor.
// One quotient bit per cycle; depends on gvw_pkg.
module gvw_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import gvw_pkg::*;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [31:0] mag, q;
  logic [31:0] rem;
  logic [30:0] d;
  logic [32:0] trial;

  assign trial = {rem, mag[31]} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        neg  <= dividend[31];
        mag  <= dividend[31] ? (32'd0 - dividend) : dividend;
        rem  <= 32'd0;
        q    <= 32'd0;
        d    <= (divisor == 31'd0) ? 31'd1 : divisor;
      end else if (busy) begin
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg)
            quotient <= (rem != 32'd0) ? (32'd0 - q - 32'd1) : (32'd0 - q);
          else
            quotient <= q;
        end else begin
          cnt <= cnt + 6'd1;
          mag <= {mag[30:0], 1'b0};
          if (!trial[32]) begin
            rem <= trial[31:0];
            q   <= {q[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], mag[31]};
            q   <= {q[30:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

[design/grid_vertex_welder.sv]
// Grid vertex welder top level: snap, hash probe, insert.
// A weld runs two serial divisions (x, then y), then hash, read and
// compare, and each extra probe repeats read and compare. A clear sweeps
// all 4096 slots, one slot per cycle.
// One item at a time; the next is taken from the cycle after the result beat
// leaves. Synchronous active-high reset empties the table through the same sweep.
// Depends on gvw_pkg, gvw_if, gvw_div.
module grid_vertex_welder (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [30:0] cfg_data,
  gvw_in_if.sink  in_ch,
  gvw_out_if.source out_ch
);
  import gvw_pkg::*;
  logic [30:0] cell_size;
  state_t state, state_next;
  in_beat_t item;
  logic [63:0] key;
  logic [IdxW-1:0] slot;
  logic [CntW-1:0] probes, count;
  logic valid_bits [Capacity];
  logic [63:0] key_mem [Capacity];
  logic [IdxW-1:0] idx_mem [Capacity];
  logic [63:0] rd_key;
  logic [IdxW-1:0] rd_idx;
  logic rd_valid;
  logic div_start, div_done;
  logic [31:0] div_q;
  logic [63:0] hprod;
  logic hit, insert;
  out_beat_t res, cmp_res;

  gvw_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(state == ST_IDLE ? in_ch.data.x_coord : item.y_coord),
    .divisor(cell_size), .done(div_done), .quotient(div_q)
  );

  assign hprod = key[31:0] * 32'h7F4A7C15;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data = res;
  assign hit = rd_valid && rd_key == key;
  assign insert = !rd_valid && count != CntW'(Capacity);

  always_comb begin
    cmp_res = '0;
    cmp_res.unique_count = 13'(count);
    if (hit) begin
      cmp_res.vertex_index = 12'(rd_idx);
    end else if (insert) begin
      cmp_res.vertex_index = 12'(count);
      cmp_res.is_new = 1'b1;
      cmp_res.new_x = item.x_coord;
      cmp_res.new_y = item.y_coord;
      cmp_res.unique_count = 13'(count + 1'b1);
    end else if (!rd_valid || probes == CntW'(Capacity - 1)) begin
      cmp_res.table_full = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_ch.valid) begin
        state_next = (in_ch.data.kind == KIND_CLEAR) ? ST_CLEAR : ST_DIVX;
        div_start = (in_ch.data.kind == KIND_WELD);
      end
      ST_CLEAR: if (slot == IdxW'(Capacity - 1))
        state_next = (item.kind == KIND_CLEAR) ? ST_OUT : ST_IDLE;
      ST_DIVX: if (div_done) begin
        state_next = ST_DIVY;
        div_start = 1'b1;
      end
      ST_DIVY: if (div_done) state_next = ST_HASH;
      ST_HASH: state_next = ST_RD;
      ST_RD: state_next = ST_CMP;
      ST_CMP: if (!rd_valid || rd_key == key || probes == CntW'(Capacity - 1))
        state_next = ST_OUT;
      else state_next = ST_RD;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      slot <= '0;
      count <= '0;
      cell_size <= 31'd1;
      item.kind <= KIND_WELD;
    end else begin
      state <= state_next;
      if (cfg_we) cell_size <= cfg_data;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          slot <= '0;
        end
        ST_CLEAR: begin
          slot <= slot + 1'b1;
          if (slot == IdxW'(Capacity - 1)) begin
            count <= '0;
            res <= '0;
          end
        end
        ST_DIVX: if (div_done) key[63:32] <= div_q;
        ST_DIVY: if (div_done) key[31:0] <= div_q;
        ST_HASH: begin
          slot <= hprod[IdxW-1:0] ^ key[63:64-IdxW] ^ key[IdxW-1+32:32];
          probes <= '0;
        end
        ST_CMP: begin
          res <= cmp_res;
          if (insert) begin
            count <= count + 1'b1;
          end else if (rd_valid && !hit && probes != CntW'(Capacity - 1)) begin
            slot <= slot + 1'b1;
            probes <= probes + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR)
      valid_bits[slot] <= 1'b0;
    else if (state == ST_CMP && insert) begin
      valid_bits[slot] <= 1'b1;
      key_mem[slot] <= key;
      idx_mem[slot] <= count[IdxW-1:0];
    end
    if (state == ST_RD) begin
      rd_valid <= valid_bits[slot];
      rd_key <= key_mem[slot];
      rd_idx <= idx_mem[slot];
    end
  end
endmodule

[design/gvw_checker.sv]
// Port-level checks for grid_vertex_welder, bound to the top level.
// Depends on gvw_pkg and the channel interfaces.
module gvw_assertions (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input gvw_pkg::out_beat_t out_data
);
  import gvw_pkg::*;
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");
  a_new_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_new |-> !out_data.table_full &&
    out_data.unique_count == 13'(out_data.vertex_index) + 13'd1)
    else $error("new vertex index mismatch");
  a_old_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_new |-> out_data.new_x == 32'd0 && out_data.new_y == 32'd0)
    else $error("coordinates on non-new result");
endmodule

bind grid_vertex_welder gvw_assertions u_gvw_assertions (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data)
);
